### design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define LBPG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lbpg assertion failed");

// Next-cycle implication, off while reset is low.
`define LBPG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lbpg assertion failed");

// Next-cycle implication that stays armed through reset.
`define LBPG_ASSERT_NXT_ND(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("lbpg assertion failed");

`endif

### design/lbpg_pkg.sv
// Types, constants and per-pattern tables of the LED blink pattern generator.
package lbpg_pkg;

    localparam int DATA_W     = 32;   // time field width on the port
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam int SUM_W       = 21;  // folded byte sum, below 2^21
    localparam int PER_W       = 11;  // periods and weights, below 2^11
    localparam int RECIP_W     = 15;
    localparam int RECIP_SHIFT = 22;
    localparam int QUO_W       = SUM_W + RECIP_W - RECIP_SHIFT;
    localparam int REM_W       = PER_W + 1;  // remainder before correction, below 2*period

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF    = 3'd0,
        MODE_SOLID  = 3'd1,
        MODE_SLOW   = 3'd2,
        MODE_FAST   = 3'd3,
        MODE_DOUBLE = 3'd4,
        MODE_TRIPLE = 3'd5
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_MODE = 8'd0,
        REG_POLARITY     = 8'd1
    } t_reg_idx;

    localparam int SLOW_HALF_MS   = 500;
    localparam int FAST_HALF_MS   = 100;
    localparam int PULSE_MS       = 80;
    localparam int DOUBLE_TAIL_MS = 720;
    localparam int TRIPLE_TAIL_MS = 640;

    localparam int SLOW_PERIOD_MS   = 2 * SLOW_HALF_MS;
    localparam int FAST_PERIOD_MS   = 2 * FAST_HALF_MS;
    localparam int DOUBLE_PERIOD_MS = 3 * PULSE_MS + DOUBLE_TAIL_MS;
    localparam int TRIPLE_PERIOD_MS = 5 * PULSE_MS + TRIPLE_TAIL_MS;

    // period, 256^k mod period for bytes 1..3, floor(2^22 / period)
    typedef struct packed {
        logic [PER_W-1:0]   period;
        logic [PER_W-1:0]   w1;
        logic [PER_W-1:0]   w2;
        logic [PER_W-1:0]   w3;
        logic [RECIP_W-1:0] recip;
    } t_mod_k;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SUM_W-1:0]  sum;
    } t_s1;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SUM_W-1:0]  sum;
        logic [QUO_W-1:0]  quo;
    } t_s2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [REM_W-1:0]  rem;
    } t_s3;

    function automatic t_mod_k mod_consts(input logic [MODE_W-1:0] mode);
        t_mod_k k;
        unique case (mode)
            MODE_FAST: begin
                k.period = PER_W'(FAST_PERIOD_MS);
                k.w1     = 11'd56;
                k.w2     = 11'd136;
                k.w3     = 11'd16;
                k.recip  = 15'd20971;
            end
            MODE_DOUBLE: begin
                k.period = PER_W'(DOUBLE_PERIOD_MS);
                k.w1     = 11'd256;
                k.w2     = 11'd256;
                k.w3     = 11'd256;
                k.recip  = 15'd4369;
            end
            MODE_TRIPLE: begin
                k.period = PER_W'(TRIPLE_PERIOD_MS);
                k.w1     = 11'd256;
                k.w2     = 11'd16;
                k.w3     = 11'd976;
                k.recip  = 15'd4032;
            end
            default: begin
                // slow blink; the static patterns ignore the remainder
                k.period = PER_W'(SLOW_PERIOD_MS);
                k.w1     = 11'd256;
                k.w2     = 11'd536;
                k.w3     = 11'd216;
                k.recip  = 15'd4194;
            end
        endcase
        return k;
    endfunction

    // Level of the pattern at offset t within its period.
    function automatic logic blink_on(input logic [MODE_W-1:0] mode,
                                      input logic [PER_W-1:0]  t);
        logic p1, p2, p3;
        p1 = t < PER_W'(PULSE_MS);
        p2 = (t >= PER_W'(2 * PULSE_MS)) && (t < PER_W'(3 * PULSE_MS));
        p3 = (t >= PER_W'(4 * PULSE_MS)) && (t < PER_W'(5 * PULSE_MS));
        unique case (mode)
            MODE_SOLID:  return 1'b1;
            MODE_SLOW:   return t < PER_W'(SLOW_HALF_MS);
            MODE_FAST:   return t < PER_W'(FAST_HALF_MS);
            MODE_DOUBLE: return p1 || p2;
            MODE_TRIPLE: return p1 || p2 || p3;
            default:     return 1'b0;
        endcase
    endfunction

endpackage

### design/lbpg_fold.sv
// Stage 1: folds the four time bytes into a small sum congruent modulo the period.
module lbpg_fold import lbpg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [DATA_W-1:0] i_time,
    input  logic [MODE_W-1:0] i_mode,
    input  logic              i_ready,
    output logic              o_ready,
    output logic              o_valid,
    output t_s1               o_s1
);

    localparam int PROD_W = 8 + PER_W;

    logic              r_valid;
    t_s1               r_s1;
    t_s1               n_s1;
    t_mod_k            k;
    logic [PROD_W-1:0] prod1, prod2, prod3;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        k     = mod_consts(i_mode);
        prod1 = PROD_W'(i_time[15:8])  * PROD_W'(k.w1);
        prod2 = PROD_W'(i_time[23:16]) * PROD_W'(k.w2);
        prod3 = PROD_W'(i_time[31:24]) * PROD_W'(k.w3);
        n_s1.mode = i_mode;
        n_s1.sum  = SUM_W'(i_time[7:0]) + SUM_W'(prod1) + SUM_W'(prod2) + SUM_W'(prod3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

### design/lbpg_divide.sv
// Stages 2 and 3: reciprocal quotient estimate, then remainder of the folded sum.
module lbpg_divide import lbpg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_s1  i_s1,
    input  logic i_ready,
    output logic o_ready,
    output logic o_valid,
    output t_s3  o_s3
);

    localparam int QP_W = SUM_W + RECIP_W;
    localparam int QM_W = QUO_W + PER_W;

    logic             r_v2, r_v3;
    t_s2              r_s2;
    t_s3              r_s3;
    t_s2              n_s2;
    t_s3              n_s3;
    t_mod_k           k1, k2;
    logic [QP_W-1:0]  qprod;
    logic [QM_W-1:0]  qm;
    logic [SUM_W-1:0] diff;
    logic             ready3;

    assign ready3  = !r_v3 || i_ready;
    assign o_ready = !r_v2 || ready3;

    always_comb begin
        k1    = mod_consts(i_s1.mode);
        qprod = QP_W'(i_s1.sum) * QP_W'(k1.recip);
        n_s2.mode = i_s1.mode;
        n_s2.sum  = i_s1.sum;
        n_s2.quo  = qprod[RECIP_SHIFT +: QUO_W];
    end

    // estimate is at most one short, so the remainder stays below twice the period
    always_comb begin
        k2   = mod_consts(r_s2.mode);
        qm   = QM_W'(r_s2.quo) * QM_W'(k2.period);
        diff = r_s2.sum - qm[SUM_W-1:0];
        n_s3.mode = r_s2.mode;
        n_s3.rem  = diff[REM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v2 <= i_valid;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s2 <= n_s2;
        end
        if (ready3 && r_v2) begin
            r_s3 <= n_s3;
        end
    end

    assign o_valid = r_v3;
    assign o_s3    = r_s3;

endmodule

### design/lbpg_level.sv
// Stage 4: remainder correction, pattern decode and output register.
module lbpg_level import lbpg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_s3  i_s3,
    input  logic i_polarity,
    input  logic i_stall,
    output logic o_ready,
    output logic o_valid,
    output logic o_led_on,
    output logic o_pin_drive
);

    logic             r_valid;
    logic             r_led_on;
    logic             r_pin_drive;
    logic             n_led_on;
    t_mod_k           k;
    logic [REM_W-1:0] rem_fix;

    assign o_ready = !r_valid || !i_stall;

    always_comb begin
        k       = mod_consts(i_s3.mode);
        rem_fix = (i_s3.rem >= REM_W'(k.period)) ? i_s3.rem - REM_W'(k.period) : i_s3.rem;
        n_led_on = blink_on(i_s3.mode, rem_fix[PER_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_led_on    <= n_led_on;
            r_pin_drive <= i_polarity ? n_led_on : !n_led_on;
        end
    end

    assign o_valid     = r_valid;
    assign o_led_on    = r_led_on;
    assign o_pin_drive = r_pin_drive;

endmodule

### design/led_blink_pattern_generator_core.sv
// Top level of the LED blink pattern generator: config registers and the four-stage pipeline.
// One timestamp is taken every cycle given no stall downstream. Its result passes in order
// through the four register stages: the byte fold, the reciprocal multiply for the
// quotient, the remainder multiply-subtract, and the final correction with the pattern
// decode; each holds one item, so a stall at the output fills them in place and
// back-pressures the input. Only the low min(TIME_WIDTH, 32) bits of i_time_ms are used.
// Config writes are always taken (o_cfg_ready is high) and must only happen with no item
// in flight.
module led_blink_pattern_generator_core import lbpg_pkg::*; #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [DATA_W-1:0]     i_time_ms,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_led_on,
    output logic                  o_pin_drive
);

    localparam int USE_W = (TIME_WIDTH < DATA_W) ? TIME_WIDTH : DATA_W;
    localparam logic [DATA_W-1:0] TIME_MASK = {DATA_W{1'b1}} >> (DATA_W - USE_W);

    logic [MODE_W-1:0] r_mode;
    logic              r_polarity;
    logic              fold_ready, div_ready, lvl_ready;
    logic              fold_valid, div_valid;
    t_s1               fold_s1;
    t_s3               div_s3;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_OFF;
            r_polarity <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_PATTERN_MODE: r_mode     <= i_cfg_data[MODE_W-1:0];
                REG_POLARITY:     r_polarity <= i_cfg_data[0];
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    lbpg_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_time  (i_time_ms & TIME_MASK),
        .i_mode  (r_mode),
        .i_ready (div_ready),
        .o_ready (fold_ready),
        .o_valid (fold_valid),
        .o_s1    (fold_s1)
    );

    lbpg_divide u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fold_valid),
        .i_s1    (fold_s1),
        .i_ready (lvl_ready),
        .o_ready (div_ready),
        .o_valid (div_valid),
        .o_s3    (div_s3)
    );

    lbpg_level u_level (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (div_valid),
        .i_s3        (div_s3),
        .i_polarity  (r_polarity),
        .i_stall     (i_stall),
        .o_ready     (lvl_ready),
        .o_valid     (o_valid),
        .o_led_on    (o_led_on),
        .o_pin_drive (o_pin_drive)
    );

    assign o_stall = !fold_ready;

endmodule

### design/lbpg_checker.sv
// Port-level assertion checker for the LED blink pattern generator, with its bind.
`include "assert_macros.svh"

module lbpg_checker import lbpg_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic                  o_led_on,
    input logic                  o_pin_drive
);

    // shadow copies of the config registers, tracked from port transfers
    logic [MODE_W-1:0] r_mode;
    logic              r_polarity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_OFF;
            r_polarity <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_PATTERN_MODE) begin
                r_mode <= i_cfg_data[MODE_W-1:0];
            end
            if (i_cfg_index == REG_POLARITY) begin
                r_polarity <= i_cfg_data[0];
            end
        end
    end

    `LBPG_ASSERT_IMP(a_pin_polarity, i_clk, i_rst_n, o_valid, o_pin_drive == (r_polarity ? o_led_on : !o_led_on))
    `LBPG_ASSERT_IMP(a_dark_modes, i_clk, i_rst_n, o_valid && (r_mode == MODE_OFF || r_mode > MODE_TRIPLE), !o_led_on)
    `LBPG_ASSERT_IMP(a_solid_mode, i_clk, i_rst_n, o_valid && r_mode == MODE_SOLID, o_led_on)
    `LBPG_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_led_on) && $stable(o_pin_drive))
    `LBPG_ASSERT_NXT_ND(a_reset_flush, i_clk, !i_rst_n, !o_valid)

endmodule

bind led_blink_pattern_generator_core lbpg_checker u_lbpg_checker (.*);
